// ----- hdl/tared_windowed_average_scale_macros.svh -----
// Assertion macros for the scale RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef TARED_WINDOWED_AVERAGE_SCALE_MACROS_SVH
`define TARED_WINDOWED_AVERAGE_SCALE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TWAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TWAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/twas_pkg.sv -----
`default_nettype none

package twas_pkg;

  localparam int WINDOW   = 20;
  localparam int SAMPLE_W = 12;
  localparam int ZERO_W   = SAMPLE_W + 1;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
  localparam int STEP_W   = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    DISP_NONE   = 2'd0,
    DISP_NORMAL = 2'd1,
    DISP_DIRTY  = 2'd2,
    DISP_NASTY  = 2'd3
  } disp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- hdl/twas_ring.sv -----
`default_nettype none

module twas_ring
  import twas_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [SLOT_W-1:0]   wr_addr,
  input  wire logic [SAMPLE_W-1:0] wr_data,
  input  wire logic [SLOT_W-1:0]   rd_addr,
  output logic      [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem_r [WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/twas_div.sv -----
`default_nettype none

module twas_div
  import twas_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output div_stat_t             stat,
  output logic      [SUM_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [SUM_W-1:0]  quo_r;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W+1:0]  diff;
  logic              fits;

  // Restoring division: one quotient bit per cycle, dividend bits enter from the top.
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign fits   = ~diff[CNT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (step_r == STEP_W'(SUM_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r  <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_r  <= {quo_r[SUM_W-2:0], fits};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ----- hdl/tared_windowed_average_scale.sv -----
// Tared windowed average scale.
// Input channel (in_valid / in_stall): one beat per loop tick, carrying the
// 12-bit sample and the five button levels. A beat is taken when in_valid is
// high and in_stall is low; in_stall is high from the cycle after a beat is
// taken until its result has been loaded into the output register.
// Output channel (out_valid / out_stall): one beat per input beat, carrying
// zeroed, is_tared and dispense. The result register holds while out_stall
// is high, and a new input beat may be taken while it still waits.
// Each item stores its sample in the window ring, then the ring is read one
// entry per cycle into an accumulator, then a restoring divider produces the
// average one bit per cycle, then a final step forms the result and loads it
// once the output register is free. A new item is taken only once the
// previous result has been loaded into the output register.
// Synchronous active-low reset empties the window, clears the tare offset and
// tared flag, drops out_valid and leaves in_stall low; no clearing pass is
// needed since entries are read only after they were written.
`default_nettype none

module tared_windowed_average_scale
  import twas_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [SAMPLE_W-1:0]      in_sample,
  input  wire logic                     in_tare_button,
  input  wire logic                     in_reset_button,
  input  wire logic                     in_normal_button,
  input  wire logic                     in_dirty_button,
  input  wire logic                     in_nasty_button,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [ZERO_W-1:0]      out_zeroed,
  output logic                          out_is_tared,
  output logic [1:0]                    out_dispense
);

`include "tared_windowed_average_scale_macros.svh"

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV, S_FIN} state_t;

  state_t              state_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                filled_r;
  logic [SAMPLE_W-1:0] offset_r;
  logic                tared_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    idx_r;
  logic                rd_vld_r;
  logic [SUM_W-1:0]    acc_r;
  logic                tare_b_r;
  logic                rst_b_r;
  logic                normal_b_r;
  logic                dirty_b_r;
  logic                nasty_b_r;
  logic                out_valid_r;
  logic [ZERO_W-1:0]   out_zeroed_r;
  logic                out_tared_r;
  disp_t               out_disp_r;

  logic                accept;
  logic                wrap;
  logic [SLOT_W-1:0]   slot_nxt;
  logic                filled_nxt;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                issue;
  logic                div_start;
  logic [SAMPLE_W-1:0] rd_data;
  div_stat_t           div_stat;
  logic [SUM_W-1:0]    quotient;
  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] avg_post;
  logic [ZERO_W-1:0]   zeroed;
  logic                tared_pre;
  disp_t               disp;
  logic                tared_post;
  logic [SAMPLE_W-1:0] offset_post;
  logic                out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Write slot advance; the window counts as full once the slot wraps.
  assign wrap       = (slot_r == SLOT_W'(WINDOW - 1));
  assign slot_nxt   = wrap ? '0 : slot_r + 1'b1;
  assign filled_nxt = filled_r | wrap;
  assign cnt_nxt    = filled_nxt ? CNT_W'(WINDOW) : CNT_W'(slot_nxt);

  assign issue     = (state_r == S_SUM) && (idx_r < cnt_r);
  assign div_start = (state_r == S_SUM) && !issue && !rd_vld_r;

  twas_ring u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (slot_r),
    .wr_data (in_sample),
    .rd_addr (idx_r[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  twas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (cnt_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // The average never exceeds the largest sample, so the low bits hold it.
  assign avg       = quotient[SAMPLE_W-1:0];
  assign zeroed    = {1'b0, avg} - {1'b0, offset_r};
  assign avg_post  = rst_b_r ? '0 : avg;
  assign tared_pre = rst_b_r ? 1'b0 : tared_r;

  always_comb begin
    disp = DISP_NONE;
    if (!tare_b_r && tared_pre) begin
      if (normal_b_r) begin
        disp = DISP_NORMAL;
      end else if (dirty_b_r) begin
        disp = DISP_DIRTY;
      end else if (nasty_b_r) begin
        disp = DISP_NASTY;
      end
    end
  end

  assign tared_post  = tare_b_r ? 1'b1 : (tared_pre && (disp == DISP_NONE));
  assign offset_post = tare_b_r ? avg_post : (rst_b_r ? '0 : offset_r);
  assign out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      offset_r    <= '0;
      tared_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            slot_r     <= slot_nxt;
            filled_r   <= filled_nxt;
            cnt_r      <= cnt_nxt;
            idx_r      <= '0;
            rd_vld_r   <= 1'b0;
            acc_r      <= '0;
            tare_b_r   <= in_tare_button;
            rst_b_r    <= in_reset_button;
            normal_b_r <= in_normal_button;
            dirty_b_r  <= in_dirty_button;
            nasty_b_r  <= in_nasty_button;
            state_r    <= S_SUM;
          end
        end
        S_SUM: begin
          // Read data arrives in the cycle after its address is issued.
          rd_vld_r <= issue;
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
          if (rd_vld_r) begin
            acc_r <= acc_r + SUM_W'(rd_data);
          end
          if (div_start) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_zeroed_r <= zeroed;
            out_tared_r  <= tared_post;
            out_disp_r   <= disp;
            offset_r     <= offset_post;
            tared_r      <= tared_post;
            if (rst_b_r) begin
              slot_r   <= '0;
              filled_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_zeroed   = $signed(out_zeroed_r);
  assign out_is_tared = out_tared_r;
  assign out_dispense = out_disp_r;

  `TWAS_ASSERT_IMP(a_cnt_range, state_r == S_SUM, (cnt_r != '0) && (cnt_r <= CNT_W'(WINDOW)), "window count out of range")
  `TWAS_ASSERT_IMP(a_slot_range, 1'b1, {1'b0, slot_r} < (SLOT_W + 1)'(WINDOW), "write slot beyond window")
  `TWAS_ASSERT_NXT(a_accept_sum, accept, state_r == S_SUM, "accepted beat did not start summing")
  `TWAS_ASSERT_IMP(a_fin_idle_div, state_r == S_FIN, !div_stat.busy, "divider busy in final step")
  `TWAS_ASSERT_NXT(a_fin_out, (state_r == S_FIN) && out_free, out_valid && (state_r == S_IDLE), "result not presented")

endmodule

`default_nettype wire

// ----- sim/tared_windowed_average_scale_test.sv -----
`timescale 1ns / 100ps

module tared_windowed_average_scale_test;
  import twas_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                tare;
    logic                reset_btn;
    logic                normal;
    logic                dirty;
    logic                nasty;
  } tick_t;

  typedef struct packed {
    logic signed [ZERO_W-1:0] zeroed;
    logic                     is_tared;
    disp_t                    dispense;
  } reading_t;

  typedef struct packed {
    tick_t    tick;
    logic     typed;
    reading_t want;
  } script_row_t;

  localparam reading_t NO_WANT = '{13'sd0, 1'b0, DISP_NONE};
  localparam int SCRIPT_LEN = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_AFTER = 700;
  localparam int DRAIN_AT = 400;
  localparam int SETTLE_CYCLES = 60;

  // Rows with typed = 1 carry a fixed result that follows from the rows since the last reset.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{12'd4095, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{13'sd4095, 1'b0, DISP_NONE}},
    '{'{12'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd123,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{13'sd123, 1'b1, DISP_NONE}},
    '{'{12'd0,    1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, '{13'sd0, 1'b0, DISP_NORMAL}},
    '{'{12'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, '{13'sd0, 1'b0, DISP_NONE}},
    '{'{12'd4095, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_WANT},
    '{'{12'd4095, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
    '{'{12'hAAA,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'h555,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd0,    1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WANT},
    '{'{12'd4095, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd4095, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd1,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic in_tare_button = 1'b0;
  logic in_reset_button = 1'b0;
  logic in_normal_button = 1'b0;
  logic in_dirty_button = 1'b0;
  logic in_nasty_button = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ZERO_W-1:0] out_zeroed;
  logic out_is_tared;
  logic [1:0] out_dispense;

  // Scale state as the block should hold it.
  logic [SAMPLE_W-1:0] ring [WINDOW];
  int unsigned slot;
  logic filled;
  logic [SAMPLE_W-1:0] offset;
  logic tared;

  reading_t readings_due [$];
  reading_t oldest;
  int mismatches = 0;
  int items_sent = 0;
  logic calm = 1'b0;
  logic stalls_on = 1'b1;
  bit gaps_on = 1'b1;
  int stall_left = 0;

  always #1 clk = ~clk;

  tared_windowed_average_scale u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_tare_button   (in_tare_button),
    .in_reset_button  (in_reset_button),
    .in_normal_button (in_normal_button),
    .in_dirty_button  (in_dirty_button),
    .in_nasty_button  (in_nasty_button),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_zeroed       (out_zeroed),
    .out_is_tared     (out_is_tared),
    .out_dispense     (out_dispense)
  );

  function automatic int unsigned ring_average();
    int unsigned count;
    int unsigned sum;
    count = filled ? WINDOW : slot;
    sum = 0;
    if (count == 0) begin
      return 0;
    end
    for (int i = 0; i < count; i++) begin
      sum += ring[i];
    end
    return sum / count;
  endfunction

  function automatic void clear_scale();
    foreach (ring[i]) ring[i] = '0;
    slot = 0;
    filled = 1'b0;
    offset = '0;
    tared = 1'b0;
  endfunction

  function automatic reading_t weigh_tick(tick_t t);
    reading_t r;
    int diff;
    ring[slot] = t.sample;
    slot++;
    if (slot == WINDOW) begin
      slot = 0;
      filled = 1'b1;
    end
    diff = int'(ring_average()) - int'(offset);
    r.zeroed = ZERO_W'(diff);
    r.dispense = DISP_NONE;
    if (t.reset_btn) begin
      clear_scale();
    end
    if (t.tare) begin
      // The capture sees the window after any reset in the same tick.
      offset = SAMPLE_W'(ring_average());
      tared = 1'b1;
    end else if (tared) begin
      if (t.normal) begin
        r.dispense = DISP_NORMAL;
      end else if (t.dirty) begin
        r.dispense = DISP_DIRTY;
      end else if (t.nasty) begin
        r.dispense = DISP_NASTY;
      end
      if (r.dispense != DISP_NONE) begin
        tared = 1'b0;
      end
    end
    r.is_tared = tared;
    return r;
  endfunction

  // Presents one tick and waits for its beat. Valid stays high afterwards
  // unless a gap is taken, so back-to-back ticks never lower it.
  task automatic send_tick(tick_t t, logic typed, reading_t typed_want);
    reading_t predicted;
    in_valid <= 1'b1;
    in_sample <= t.sample;
    in_tare_button <= t.tare;
    in_reset_button <= t.reset_btn;
    in_normal_button <= t.normal;
    in_dirty_button <= t.dirty;
    in_nasty_button <= t.nasty;
    do @(posedge clk); while (in_stall);
    predicted = weigh_tick(t);
    readings_due.push_back(typed ? typed_want : predicted);
    items_sent++;
    if (!calm && items_sent >= SCRIPT_LEN + CALM_AFTER) begin
      calm <= 1'b1;
    end
    if (!calm && gaps_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  function automatic tick_t quiet_tick(logic [SAMPLE_W-1:0] sample);
    tick_t t;
    t = '0;
    t.sample = sample;
    return t;
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_near(int level, int spread);
    int v;
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  // A full weighing: optional reset, a settled run at one level, tare, a settled
  // run at a newly picked level, then one or more dispense buttons.
  task automatic weigh_cycle();
    tick_t t;
    int level;
    int spread;
    int run;
    if ($urandom_range(0, 5) == 0) begin
      t = quiet_tick(SAMPLE_W'($urandom));
      t.reset_btn = 1'b1;
      send_tick(t, 1'b0, NO_WANT);
    end
    spread = ($urandom_range(0, 2) == 0) ? 20 : 0;
    level = pick_level();
    run = $urandom_range(1, 25);
    repeat (run) send_tick(quiet_tick(sample_near(level, spread)), 1'b0, NO_WANT);
    t = quiet_tick(sample_near(level, spread));
    t.tare = 1'b1;
    send_tick(t, 1'b0, NO_WANT);
    level = pick_level();
    run = $urandom_range(0, 25);
    repeat (run) send_tick(quiet_tick(sample_near(level, spread)), 1'b0, NO_WANT);
    t = quiet_tick(sample_near(level, spread));
    t.normal = 1'($urandom_range(0, 1));
    t.dirty = 1'($urandom_range(0, 1));
    t.nasty = 1'($urandom_range(0, 1));
    if (!(t.normal || t.dirty || t.nasty)) begin
      t.nasty = 1'b1;
    end
    send_tick(t, 1'b0, NO_WANT);
  endtask

  task automatic noise_burst();
    tick_t t;
    repeat ($urandom_range(1, 10)) begin
      t.sample = SAMPLE_W'($urandom);
      t.tare = ($urandom_range(0, 3) == 0);
      t.reset_btn = ($urandom_range(0, 7) == 0);
      t.normal = 1'($urandom_range(0, 1));
      t.dirty = 1'($urandom_range(0, 1));
      t.nasty = 1'($urandom_range(0, 1));
      send_tick(t, 1'b0, NO_WANT);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && stalls_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        $display("%0t: reading with none expected: zeroed %0d is_tared %0d dispense %0d",
                 $realtime, out_zeroed, out_is_tared, out_dispense);
        mismatches++;
      end else begin
        oldest = readings_due.pop_front();
        if (out_zeroed !== oldest.zeroed) begin
          $display("%0t: zeroed expected %0d actual %0d", $realtime, oldest.zeroed,
                   out_zeroed);
          mismatches++;
        end
        if (out_is_tared !== oldest.is_tared) begin
          $display("%0t: is_tared expected %0d actual %0d", $realtime, oldest.is_tared,
                   out_is_tared);
          mismatches++;
        end
        if (out_dispense !== oldest.dispense) begin
          $display("%0t: dispense expected %0d actual %0d", $realtime, oldest.dispense,
                   out_dispense);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bit drained;
    drained = 1'b0;
    clear_scale();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_tick(SCRIPT[i].tick, SCRIPT[i].typed, SCRIPT[i].want);
    end

    while (items_sent < SCRIPT_LEN + RANDOM_ITEMS) begin
      stalls_on <= ($urandom_range(0, 3) != 0);
      gaps_on = ($urandom_range(0, 3) != 0);
      // Hold the sender off once until every reading has come back.
      if (!drained && items_sent >= SCRIPT_LEN + DRAIN_AT) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) < 7) begin
        weigh_cycle();
      end else begin
        noise_burst();
      end
    end

    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tared_windowed_average_scale_test OK");
    end else begin
      $display("tared_windowed_average_scale_test NOT OK");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tared_windowed_average_scale_test NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/twas_pkg.sv
hdl/twas_ring.sv
hdl/twas_div.sv
hdl/tared_windowed_average_scale.sv
sim/tared_windowed_average_scale_test.sv
